@@ rtl/core/cau_pkg.sv @@
// shared types and constants of the complex arithmetic unit
`timescale 1ns / 1ps

package cau_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int WORD_W        = 32;
   localparam int PROD_W        = 64;
   // quotient bits kept by the divider, integer and fraction plus round bit
   localparam int DIV_Q_BITS    = 34;

   localparam logic [WORD_W-1:0] POS_LIM = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] NEG_LIM = 32'h8000_0000;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } cau_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_SAT  = 2'd1,
      STATUS_DIVZ = 2'd2
   } cau_status_type;

   typedef struct packed {
      cau_kind_type              kind;
      logic signed [WORD_W-1:0]  a_re;
      logic signed [WORD_W-1:0]  a_im;
      logic signed [WORD_W-1:0]  b_re;
      logic signed [WORD_W-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  res_re;
      logic signed [WORD_W-1:0]  res_im;
      cau_status_type            status;
   } rsp_type;

   // sign and magnitude of one result part before scaling
   typedef struct packed {
      logic              neg;
      logic [PROD_W-1:0] mag;
   } lane_type;

   typedef struct packed {
      cau_kind_type      kind;
      logic              dz;
      logic [PROD_W-1:0] den;
      lane_type          re;
      lane_type          im;
   } front_type;

   // partial remainder and shared dividend / quotient register of one divider lane
   typedef struct packed {
      logic [PROD_W-1:0]     rem;
      logic [DIV_Q_BITS-1:0] qn;
      logic                  ovf;
   } dlane_type;

   typedef struct packed {
      front_type f;
      dlane_type re;
      dlane_type im;
   } div_type;

endpackage

@@ rtl/core/cau_if.sv @@
// request and response stream interfaces
`timescale 1ns / 1ps

interface cau_req_if;
   logic             valid;
   logic             ready;
   cau_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cau_rsp_if;
   logic             valid;
   logic             ready;
   cau_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/cau_front.sv @@
// front stages: products, sums of products, sign and magnitude
`timescale 1ns / 1ps

module cau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  cau_pkg::req_type    in_data,
   output logic                out_valid,
   output cau_pkg::front_type  out_data
);

   typedef struct packed {
      cau_pkg::cau_kind_type  kind;
      logic signed [63:0]     p_rr;
      logic signed [63:0]     p_ii;
      logic signed [63:0]     p_ri;
      logic signed [63:0]     p_ir;
      logic signed [63:0]     p_bbr;
      logic signed [63:0]     p_bbi;
      logic [32:0]            add_re;
      logic [32:0]            add_im;
   } s1_type;

   typedef struct packed {
      cau_pkg::cau_kind_type  kind;
      logic [64:0]            sum_re;
      logic [64:0]            sum_im;
      logic [63:0]            den;
   } s2_type;

   function automatic cau_pkg::lane_type to_lane(input logic [64:0] s);
      cau_pkg::lane_type l;
      logic [64:0]       ns;
      ns    = 65'd0 - s;
      l.neg = s[64];
      l.mag = s[64] ? ns[63:0] : s[63:0];
      return l;
   endfunction

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   cau_pkg::front_type s3_in, s3_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // stage 1: six products and the add / subtract sums
   always_comb begin
      s1_in.kind  = in_data.kind;
      s1_in.p_rr  = in_data.a_re * in_data.b_re;
      s1_in.p_ii  = in_data.a_im * in_data.b_im;
      s1_in.p_ri  = in_data.a_re * in_data.b_im;
      s1_in.p_ir  = in_data.a_im * in_data.b_re;
      s1_in.p_bbr = in_data.b_re * in_data.b_re;
      s1_in.p_bbi = in_data.b_im * in_data.b_im;
      if (in_data.kind == cau_pkg::KIND_SUB) begin
         s1_in.add_re = {in_data.a_re[31], in_data.a_re} - {in_data.b_re[31], in_data.b_re};
         s1_in.add_im = {in_data.a_im[31], in_data.a_im} - {in_data.b_im[31], in_data.b_im};
      end else begin
         s1_in.add_re = {in_data.a_re[31], in_data.a_re} + {in_data.b_re[31], in_data.b_re};
         s1_in.add_im = {in_data.a_im[31], in_data.a_im} + {in_data.b_im[31], in_data.b_im};
      end
   end

   // stage 2: divisor and exact sums of products, or the sign-extended add / subtract sums
   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.den  = $unsigned(s1_ff.p_bbr) + $unsigned(s1_ff.p_bbi);
      case (s1_ff.kind)
         cau_pkg::KIND_MUL: begin
            s2_in.sum_re = {s1_ff.p_rr[63], s1_ff.p_rr} - {s1_ff.p_ii[63], s1_ff.p_ii};
            s2_in.sum_im = {s1_ff.p_ri[63], s1_ff.p_ri} + {s1_ff.p_ir[63], s1_ff.p_ir};
         end
         cau_pkg::KIND_DIV: begin
            s2_in.sum_re = {s1_ff.p_rr[63], s1_ff.p_rr} + {s1_ff.p_ii[63], s1_ff.p_ii};
            s2_in.sum_im = {s1_ff.p_ir[63], s1_ff.p_ir} - {s1_ff.p_ri[63], s1_ff.p_ri};
         end
         default: begin
            s2_in.sum_re = {{32{s1_ff.add_re[32]}}, s1_ff.add_re};
            s2_in.sum_im = {{32{s1_ff.add_im[32]}}, s1_ff.add_im};
         end
      endcase
   end

   // stage 3: sign and magnitude, zero divisor
   always_comb begin
      s3_in.kind = s2_ff.kind;
      s3_in.den  = s2_ff.den;
      s3_in.dz   = (s2_ff.den == 64'd0);
      s3_in.re   = to_lane(s2_ff.sum_re);
      s3_in.im   = to_lane(s2_ff.sum_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

@@ rtl/core/cau_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, two lanes
`timescale 1ns / 1ps

module cau_div_pipe #(
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  cau_pkg::front_type  in_data,
   output logic                out_valid,
   output cau_pkg::div_type    out_data
);

   localparam int Q  = cau_pkg::DIV_Q_BITS;
   localparam int NW = Q + cau_pkg::PROD_W;

   // dividend scaled by the fraction bits and the round bit
   function automatic cau_pkg::dlane_type prep(input logic [63:0] mag,
                                               input logic [63:0] den);
      cau_pkg::dlane_type d;
      logic [NW-1:0]      num;
      num   = NW'(mag) << (FRAC_BITS + 1);
      d.rem = num[NW-1:Q];
      d.qn  = num[Q-1:0];
      d.ovf = (num[NW-1:Q] >= den);
      return d;
   endfunction

   function automatic cau_pkg::dlane_type step(input cau_pkg::dlane_type d,
                                               input logic [63:0] den);
      cau_pkg::dlane_type o;
      logic [64:0]        rs;
      logic [64:0]        df;
      rs    = {d.rem, d.qn[Q-1]};
      df    = rs - {1'b0, den};
      o.ovf = d.ovf;
      if (rs >= {1'b0, den}) begin
         o.rem = df[63:0];
         o.qn  = {d.qn[Q-2:0], 1'b1};
      end else begin
         o.rem = rs[63:0];
         o.qn  = {d.qn[Q-2:0], 1'b0};
      end
      return o;
   endfunction

   cau_pkg::div_type stg_in [Q];
   cau_pkg::div_type stg_ff [Q];
   logic [Q-1:0]     vld_ff;

   for (genvar j = 0; j < Q; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign stg_in[j].f  = in_data;
         assign stg_in[j].re = step(prep(in_data.re.mag, in_data.den), in_data.den);
         assign stg_in[j].im = step(prep(in_data.im.mag, in_data.den), in_data.den);
      end else begin : g_next
         assign stg_in[j].f  = stg_ff[j-1].f;
         assign stg_in[j].re = step(stg_ff[j-1].re, stg_ff[j-1].f.den);
         assign stg_in[j].im = step(stg_ff[j-1].im, stg_ff[j-1].f.den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Q-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < Q; j++) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   assign out_valid = vld_ff[Q-1];
   assign out_data  = stg_ff[Q-1];

   // without overflow the partial remainder always stays below the divisor
   a_rem_re: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[Q-1] && stg_ff[Q-1].f.kind == cau_pkg::KIND_DIV && !stg_ff[Q-1].re.ovf)
      |-> (stg_ff[Q-1].re.rem < stg_ff[Q-1].f.den))
      else $error("real lane remainder not below divisor");

   a_rem_im: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[Q-1] && stg_ff[Q-1].f.kind == cau_pkg::KIND_DIV && !stg_ff[Q-1].im.ovf)
      |-> (stg_ff[Q-1].im.rem < stg_ff[Q-1].f.den))
      else $error("imaginary lane remainder not below divisor");

endmodule

@@ rtl/core/cau_pack.sv @@
// rounding, saturation and status, output register
`timescale 1ns / 1ps

module cau_pack #(
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  cau_pkg::div_type  in_data,
   output logic              out_valid,
   output cau_pkg::rsp_type  out_data
);

   localparam int Q  = cau_pkg::DIV_Q_BITS;
   localparam int RB = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

   typedef struct packed {
      logic        neg;
      logic        force_sat;
      logic [63:0] m;
   } rlane_type;

   typedef struct packed {
      logic      divz;
      rlane_type re;
      rlane_type im;
   } rnd_type;

   function automatic rlane_type round_lane(input cau_pkg::cau_kind_type kind,
                                            input cau_pkg::lane_type l,
                                            input cau_pkg::dlane_type d);
      rlane_type r;
      logic      rbit;
      logic [Q-1:0] qr;
      rbit        = (FRAC_BITS > 0) ? l.mag[RB] : 1'b0;
      qr          = (d.qn >> 1) + Q'(d.qn[0]);
      r.neg       = l.neg;
      r.force_sat = 1'b0;
      case (kind)
         cau_pkg::KIND_MUL: r.m = (l.mag >> FRAC_BITS) + 64'(rbit);
         cau_pkg::KIND_DIV: begin
            r.m         = 64'(qr);
            r.force_sat = d.ovf;
         end
         default: r.m = l.mag;
      endcase
      return r;
   endfunction

   // {saturated, value}
   function automatic logic [32:0] sat_lane(input rlane_type r);
      logic [63:0] nm;
      logic [32:0] o;
      nm = 64'd0 - r.m;
      if (!r.neg) begin
         if (r.force_sat || r.m > 64'(cau_pkg::POS_LIM)) o = {1'b1, cau_pkg::POS_LIM};
         else o = {1'b0, r.m[31:0]};
      end else begin
         if (r.force_sat || r.m > 64'(cau_pkg::NEG_LIM)) o = {1'b1, cau_pkg::NEG_LIM};
         else o = {1'b0, nm[31:0]};
      end
      return o;
   endfunction

   rnd_type          r_in, r_ff;
   cau_pkg::rsp_type o_in, o_ff;
   logic             r_valid_ff, o_valid_ff;
   logic [32:0]      sre, sim;

   always_comb begin
      r_in.divz = (in_data.f.kind == cau_pkg::KIND_DIV) && in_data.f.dz;
      r_in.re   = round_lane(in_data.f.kind, in_data.f.re, in_data.re);
      r_in.im   = round_lane(in_data.f.kind, in_data.f.im, in_data.im);
   end

   always_comb begin
      sre = sat_lane(r_ff.re);
      sim = sat_lane(r_ff.im);
      if (r_ff.divz) begin
         o_in.res_re = '0;
         o_in.res_im = '0;
         o_in.status = cau_pkg::STATUS_DIVZ;
      end else begin
         o_in.res_re = sre[31:0];
         o_in.res_im = sim[31:0];
         o_in.status = (sre[32] || sim[32]) ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= in_valid;
         o_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
         o_ff <= o_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_ff;

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_ff.status == cau_pkg::STATUS_DIVZ)
      |-> (o_ff.res_re == 32'sd0 && o_ff.res_im == 32'sd0))
      else $error("divide by zero item with nonzero parts");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_ff.status == cau_pkg::STATUS_SAT)
      |-> (o_ff.res_re == cau_pkg::POS_LIM || o_ff.res_re == cau_pkg::NEG_LIM ||
           o_ff.res_im == cau_pkg::POS_LIM || o_ff.res_im == cau_pkg::NEG_LIM))
      else $error("saturated status without a part at a limit");

endmodule

@@ rtl/core/complex_arith_unit.sv @@
// top level of the complex arithmetic unit
`timescale 1ns / 1ps

// channel   dir   modport  payload
// req_if    in    sink     kind, a_re, a_im, b_re, b_im (Q16.16 signed)
// rsp_if    out   source   res_re, res_im (saturated), status
//
// one item per cycle sustained while the output is not stalled; 3 front stages
// (multiply, sum, magnitude), 34 divider stages of one quotient bit each,
// 2 stages of rounding and saturation, the last being the output register.
// every item, of any kind, runs the full pipeline so results keep order.
// synchronous reset clears only the valid bits; the datapath registers are not reset.
// a stalled output freezes all stages together; nothing is dropped or repeated.

module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);

   logic               advance;
   logic               fr_valid, dv_valid, out_valid;
   cau_pkg::front_type fr_data;
   cau_pkg::div_type   dv_data;
   cau_pkg::rsp_type   out_data;

   // the whole pipe moves unless a result sits unclaimed in the output register
   assign advance      = !out_valid || rsp_if.ready;
   assign req_if.ready = advance;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_if.valid),
      .in_data   (req_if.payload),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   // quotient bits for divide; other kinds ride along untouched
   cau_div_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_data   (fr_data),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   cau_pack #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pack (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dv_valid),
      .in_data   (dv_data),
      .out_valid (out_valid),
      .out_data  (out_data)
   );

   assign rsp_if.valid   = out_valid;
   assign rsp_if.payload = out_data;

endmodule

@@ tb/sv/tb.sv @@
// testbench for the complex arithmetic unit: random and directed items checked against a predictor
`timescale 1ns / 1ps

module tb;
   import cau_pkg::*;

   localparam int FRAC = DEF_FRAC_BITS;
   localparam int N_RANDOM = 1650;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cau_req_if req_if ();
   cau_rsp_if rsp_if ();

   complex_arith_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor: exact wide arithmetic, round half away from zero
   // ---------------------------------------------------------------
   // sign and magnitude of a 66-bit signed value
   function automatic logic [65:0] mag66(input logic signed [65:0] v, output logic neg);
      neg = v < 0;
      return neg ? -v : v;
   endfunction

   function automatic logic [31:0] pack_part(input logic neg, input logic [65:0] m,
                                             inout logic sat);
      if (!neg) begin
         if (m > 66'h7FFF_FFFF) begin
            sat = 1'b1;
            return POS_LIM;
         end
         return m[31:0];
      end
      if (m > 66'h8000_0000) begin
         sat = 1'b1;
         return NEG_LIM;
      end
      return -m[31:0];
   endfunction

   function automatic logic [65:0] round_shift(input logic [65:0] m);
      logic [65:0] r;
      r = m >> FRAC;
      if (FRAC > 0 && m[FRAC-1]) r = r + 1;
      return r;
   endfunction

   // magnitude of n/den with FRAC fraction bits, integer part capped at 2^33
   function automatic logic [65:0] frac_quot(input logic [65:0] n, input logic [65:0] den);
      logic [65:0] q0, r, q;
      q0 = n / den;
      r  = n % den;
      if (q0 > 66'h2_0000_0000) q0 = 66'h2_0000_0000;
      q = q0 << FRAC;
      for (int i = FRAC - 1; i >= 0; i--) begin
         r = r << 1;
         if (r >= den) begin
            q[i] = 1'b1;
            r = r - den;
         end
      end
      if ((r << 1) >= den) q = q + 1;
      return q;
   endfunction

   function automatic rsp_type complex_result(input req_type it);
      rsp_type o;
      logic signed [65:0] ar, ai, br, bi, sr, si;
      logic [65:0] den, mr, mi;
      logic nr, ni, sat;
      ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
      sat = 1'b0;
      case (it.kind)
         KIND_ADD: begin
            sr = ar + br; si = ai + bi;
         end
         KIND_SUB: begin
            sr = ar - br; si = ai - bi;
         end
         KIND_MUL: begin
            sr = ar * br - ai * bi; si = ar * bi + ai * br;
         end
         default: begin
            sr = ar * br + ai * bi; si = ai * br - ar * bi;
         end
      endcase
      mr = mag66(sr, nr);
      mi = mag66(si, ni);
      if (it.kind == KIND_MUL) begin
         mr = round_shift(mr);
         mi = round_shift(mi);
      end else if (it.kind == KIND_DIV) begin
         den = br * br + bi * bi;
         if (den == 0) begin
            o.res_re = '0;
            o.res_im = '0;
            o.status = STATUS_DIVZ;
            return o;
         end
         mr = frac_quot(mr, den);
         mi = frac_quot(mi, den);
      end
      if (mr == 0) nr = 1'b0;
      if (mi == 0) ni = 1'b0;
      o.res_re = pack_part(nr, mr, sat);
      o.res_im = pack_part(ni, mi, sat);
      o.status = sat ? STATUS_SAT : STATUS_OK;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // scoreboard: queue of predicted results in issue order
   // ---------------------------------------------------------------
   class result_board;
      rsp_type pending[$];
      int errors;
      int checked;
      int kind_seen[4];
      int status_seen[3];

      function void note_item(req_type it);
         pending.push_back(complex_result(it));
         kind_seen[it.kind]++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            $error("result with nothing pending: re %h im %h status %0d",
                   got.res_re, got.res_im, got.status);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         checked++;
         if (exp_r.status <= STATUS_DIVZ) status_seen[exp_r.status]++;
         if (got.res_re !== exp_r.res_re) begin
            $error("res_re expected %h actual %h", exp_r.res_re, got.res_re);
            errors++;
         end
         if (got.res_im !== exp_r.res_im) begin
            $error("res_im expected %h actual %h", exp_r.res_im, got.res_im);
            errors++;
         end
         if (got.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got.status);
            errors++;
         end
      endfunction
   endclass

   result_board board = new();

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   req_type items[$];

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return $urandom_range(0, 3) << 16;            // small integers
         4: return -($urandom_range(0, 3) << 16);
         5: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000; // within two of zero
         6: return $urandom & 32'h00FF_FFFF;              // modest positive
         7: return -($urandom & 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_item(input cau_kind_type k, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c,
                                         input logic [31:0] d);
      req_type it;
      it.kind = k; it.a_re = a; it.a_im = b; it.b_re = c; it.b_im = d;
      return it;
   endfunction

   // idle count: mostly random gaps, sometimes long back-to-back stretches
   int burst_left = 0;
   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) burst_left = $urandom_range(20, 80);
      return $urandom_range(0, 19);
   endfunction

   // valid stays high into the next item when no gap is drawn
   task automatic send_item(input req_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_item(it);
   endtask

   // response side: ready toggles with random stalls, check on acceptance
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         board.check_result(rsp_if.payload);
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      req_type it;
      int wait_cycles;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each operation at the field extremes and with small values
      for (int k = 0; k < 4; k++) begin
         items.push_back(make_item(cau_kind_type'(k), 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000));
         items.push_back(make_item(cau_kind_type'(k), 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000));
         items.push_back(make_item(cau_kind_type'(k), 32'h0001_8000, 32'hFFFF_8000,
                                   32'h0000_8000, 32'h0002_0000));
      end
      // zero divisor, with zero and nonzero dividend
      items.push_back(make_item(KIND_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0));
      items.push_back(make_item(KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0));
      // tiny divisor, quotient saturates
      items.push_back(make_item(KIND_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0));
      // rounding ties in multiply and divide
      items.push_back(make_item(KIND_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0));
      items.push_back(make_item(KIND_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0));
      items.push_back(make_item(KIND_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0));
      // add and subtract exactly at the limits and one past
      items.push_back(make_item(KIND_ADD, 32'h7FFF_FFFE, 32'h8000_0001, 32'h1, 32'hFFFF_FFFF));
      items.push_back(make_item(KIND_SUB, 32'h7FFF_FFFE, 32'h8000_0001, 32'hFFFF_FFFE,
                                32'h2));
      foreach (items[i]) send_item(items[i]);

      // random part, every kind and bit pattern
      for (int n = 0; n < N_RANDOM; n++) begin
         it = make_item(cau_kind_type'($urandom_range(0, 3)), pick_word(), pick_word(),
                        pick_word(), pick_word());
         if (it.kind == KIND_DIV && $urandom_range(0, 40) == 0) begin
            it.b_re = '0;
            it.b_im = '0;
         end
         send_item(it);
      end
      req_if.valid <= 1'b0;

      // drain, then let the pipeline settle
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);

      $display("checked %0d results: add %0d sub %0d mul %0d div %0d", board.checked,
               board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
               board.kind_seen[3]);
      $display("status mix: ok %0d saturated %0d divide-by-zero %0d", board.status_seen[0],
               board.status_seen[1], board.status_seen[2]);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         if (board.pending.size() != 0)
            $error("%0d results never arrived", board.pending.size());
         $display("tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("tb failed");
      $finish;
   end

endmodule

@@ complex_arith_unit.f @@
rtl/core/cau_pkg.sv
rtl/core/cau_if.sv
rtl/core/cau_front.sv
rtl/core/cau_div_pipe.sv
rtl/core/cau_pack.sv
rtl/core/complex_arith_unit.sv
tb/sv/tb.sv
